// ----- hdl/fpis_pkg.sv -----
// Shared types and constants for the first prime in sequence unit.
package fpis_pkg;

   localparam int OUT_WIDTH = 16;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIVIDE,
      ST_TEST,
      ST_FINISH
   } fpis_state_type;

   typedef struct packed {
      logic load_req;
      logic start_div;
      logic div_step;
      logic next_div;
      logic load_out;
      logic out_found;
   } fpis_cmd_type;

   typedef struct packed {
      logic n_small;
      logic sq_gt_n;
      logic div_last;
      logic rem_zero;
      logic out_free;
   } fpis_sts_type;

endpackage

// ----- hdl/fpis_dp.sv -----
// Datapath: candidate, divisor and square registers, bit-serial remainder unit, result register.
module fpis_dp #(
   parameter int VALUE_WIDTH = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  fpis_pkg::fpis_cmd_type               cmd,
   output fpis_pkg::fpis_sts_type               sts,
   input  logic [fpis_pkg::OUT_WIDTH-1:0]       req_candidate,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [fpis_pkg::OUT_WIDTH-1:0]       rsp_prime_value,
   output logic                                 rsp_found
);
   import fpis_pkg::*;

   localparam int W  = VALUE_WIDTH;
   localparam int CW = $clog2(W);

   logic [W+OUT_WIDTH-1:0] cand_wide;
   logic [W+OUT_WIDTH-1:0] n_wide;
   logic [W-1:0]           n_ff, n_in;
   logic [W-1:0]           d_ff, d_in;
   logic [W:0]             sq_ff, sq_in;
   logic [W-1:0]           rem_ff, rem_in;
   logic [CW-1:0]          cnt_ff, cnt_in;
   logic [W:0]             trial;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [OUT_WIDTH-1:0]   rsp_value_ff, rsp_value_in;
   logic                   rsp_found_ff, rsp_found_in;

   assign cand_wide = {{W{1'b0}}, req_candidate};
   assign n_wide    = {{OUT_WIDTH{1'b0}}, n_ff};
   assign trial     = {rem_ff, n_ff[cnt_ff]};

   always_comb begin
      n_in   = n_ff;
      d_in   = d_ff;
      sq_in  = sq_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      if (cmd.load_req) begin
         n_in  = cand_wide[W-1:0];
         d_in  = W'(2);
         sq_in = (W+1)'(4);
      end
      if (cmd.start_div) begin
         rem_in = '0;
         cnt_in = CW'(W - 1);
      end
      if (cmd.div_step) begin
         if (trial >= {1'b0, d_ff}) begin
            rem_in = W'(trial - {1'b0, d_ff});
         end else begin
            rem_in = trial[W-1:0];
         end
         cnt_in = cnt_ff - CW'(1);
      end
      if (cmd.next_div) begin
         d_in  = d_ff + W'(1);
         sq_in = sq_ff + {d_ff, 1'b1};
      end
   end

   always_comb begin
      rsp_value_in = rsp_value_ff;
      rsp_found_in = rsp_found_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
         rsp_found_in = cmd.out_found;
         rsp_value_in = cmd.out_found ? n_wide[OUT_WIDTH-1:0] : '0;
      end else begin
         rsp_valid_in = rsp_valid_ff & rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      n_ff         <= n_in;
      d_ff         <= d_in;
      sq_ff        <= sq_in;
      rem_ff       <= rem_in;
      cnt_ff       <= cnt_in;
      rsp_value_ff <= rsp_value_in;
      rsp_found_ff <= rsp_found_in;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign sts.n_small  = (n_ff < W'(2));
   assign sts.sq_gt_n  = (sq_ff > {1'b0, n_ff});
   assign sts.div_last = (cnt_ff == '0);
   assign sts.rem_zero = (rem_ff == '0);
   assign sts.out_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_prime_value = rsp_value_ff;
   assign rsp_found       = rsp_found_ff;

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> (rem_ff < d_ff))
      else $error("remainder not below divisor during division");

   a_square_tracks_divisor: assert property (@(posedge clock) disable iff (reset)
      cmd.start_div |-> ({{(W-1){1'b0}}, sq_ff} == d_ff * d_ff))
      else $error("square register does not match divisor");

   a_found_value_nonzero: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_out && cmd.out_found) |=> (rsp_prime_value != '0))
      else $error("reported prime is zero");

endmodule

// ----- hdl/fpis_ctrl.sv -----
// Controller: state machine sequencing trial division and tracking the sequence state.
module fpis_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_end_of_sequence,
   output fpis_pkg::fpis_cmd_type cmd,
   input  fpis_pkg::fpis_sts_type sts
);
   import fpis_pkg::*;

   fpis_state_type state_ff, state_in;
   logic           last_ff, last_in;
   logic           verdict_ff, verdict_in;
   logic           prime_seen_ff, prime_seen_in;
   logic           emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         last_ff       <= 1'b0;
         verdict_ff    <= 1'b0;
         prime_seen_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         last_ff       <= last_in;
         verdict_ff    <= verdict_in;
         prime_seen_ff <= prime_seen_in;
      end
   end

   assign emit = verdict_ff || (last_ff && !prime_seen_ff);

   always_comb begin
      state_in      = state_ff;
      last_in       = last_ff;
      verdict_in    = verdict_ff;
      prime_seen_in = prime_seen_ff;
      cmd           = '0;
      req_stall     = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               last_in      = req_end_of_sequence;
               verdict_in   = 1'b0;
               state_in     = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (prime_seen_ff || sts.n_small) begin
               verdict_in = 1'b0;
               state_in   = ST_FINISH;
            end else if (sts.sq_gt_n) begin
               verdict_in = 1'b1;
               state_in   = ST_FINISH;
            end else begin
               cmd.start_div = 1'b1;
               state_in      = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = ST_TEST;
            end
         end
         ST_TEST: begin
            if (sts.rem_zero) begin
               verdict_in = 1'b0;
               state_in   = ST_FINISH;
            end else begin
               cmd.next_div = 1'b1;
               state_in     = ST_CHECK;
            end
         end
         ST_FINISH: begin
            if (!emit || sts.out_free) begin
               cmd.load_out  = emit;
               cmd.out_found = verdict_ff;
               prime_seen_in = last_ff ? 1'b0 : (prime_seen_ff | verdict_ff);
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   a_load_only_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> sts.out_free)
      else $error("result loaded while output register is held");

   a_accept_starts_test: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_CHECK))
      else $error("accepted request did not start a test");

   a_single_prime_per_sequence: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && verdict_ff) |-> !prime_seen_ff)
      else $error("second prime reported in one sequence");

endmodule

// ----- hdl/first_prime_in_sequence_unit.sv -----
// Top level of the first prime in sequence unit: controller plus datapath.
//
//   Channel   Direction  Handshake             Payload
//   req_      in         req_valid/req_stall   req_candidate[15:0], req_end_of_sequence
//   rsp_      out        rsp_valid/rsp_stall   rsp_prime_value[15:0], rsp_found
//
// A request that needs no division passes ST_CHECK and ST_FINISH only. Each trial
// divisor d with d*d <= candidate adds a pass of ST_CHECK, ST_DIVIDE and ST_TEST;
// the bit-serial remainder unit runs in ST_DIVIDE. The largest 16-bit prime needs
// 254 trial divisors.
// Reset is synchronous and clears the controller and the output valid flag.
// A held response only stalls a later request that also produces a response.
module first_prime_in_sequence_unit #(
   parameter int VALUE_WIDTH = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [fpis_pkg::OUT_WIDTH-1:0] req_candidate,
   input  logic                           req_end_of_sequence,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [fpis_pkg::OUT_WIDTH-1:0] rsp_prime_value,
   output logic                           rsp_found
);
   import fpis_pkg::*;

   fpis_cmd_type cmd;
   fpis_sts_type sts;

   fpis_ctrl u_ctrl (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_end_of_sequence (req_end_of_sequence),
      .cmd                 (cmd),
      .sts                 (sts)
   );

   fpis_dp #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_candidate   (req_candidate),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_prime_value (rsp_prime_value),
      .rsp_found       (rsp_found)
   );

endmodule

// ----- tb/first_prime_in_sequence_unit_test.sv -----
// Self-checking testbench for the first prime in sequence unit.
`timescale 1ns / 100ps

module first_prime_in_sequence_unit_test;

   localparam int VALUE_BITS = fpis_pkg::OUT_WIDTH;
   localparam int RANDOM_REQUESTS = 117;
   localparam int MAX_GAP = 12;
   localparam int MAX_STALL_RUN = 30;
   localparam int CYCLES_PER_DIVISOR = VALUE_BITS + 2;
   localparam int TAIL_CYCLES = 5000;

   typedef enum int {
      STALL_NONE,
      STALL_RANDOM,
      STALL_LONG
   } stall_kind_type;

   typedef struct {
      logic [VALUE_BITS-1:0] candidate;
      logic                  closes;
      bit                    drain_first;
   } sequence_request_type;

   typedef struct {
      logic [VALUE_BITS-1:0] prime_value;
      logic                  found;
   } prime_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [VALUE_BITS-1:0] req_candidate = '0;
   logic                  req_end_of_sequence = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [VALUE_BITS-1:0] rsp_prime_value;
   logic                  rsp_found;

   sequence_request_type pending_requests[$];
   sequence_request_type next_request;
   prime_result_type     expected_primes[$];
   prime_result_type     seen_prime;
   bit                   prime_reported = 1'b0;
   int                   mismatch_count = 0;
   int                   cycle_count = 0;
   int                   cycle_limit = 2000000;
   longint               cycle_budget = 0;
   int                   burst_left = 1;
   int                   gap_left = 0;
   stall_kind_type       stall_kind = STALL_NONE;
   int                   stall_phase_left = 0;
   int                   stall_run_left = 0;
   bit                   stall_level = 1'b0;

   first_prime_in_sequence_unit #(
      .VALUE_WIDTH(VALUE_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_candidate(req_candidate),
      .req_end_of_sequence(req_end_of_sequence),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_prime_value(rsp_prime_value),
      .rsp_found(rsp_found)
   );

   always #5 clock = ~clock;

   function automatic bit candidate_is_prime(input logic [VALUE_BITS-1:0] n);
      int unsigned d;
      if (n < 2) return 1'b0;
      for (d = 2; d * d <= n; d++) begin
         if (n % d == 0) return 1'b0;
      end
      return 1'b1;
   endfunction

   task automatic predict_first_prime(input logic [VALUE_BITS-1:0] candidate,
                                      input logic closes);
      prime_result_type result;
      if (!prime_reported && candidate_is_prime(candidate)) begin
         result.prime_value = candidate;
         result.found = 1'b1;
         expected_primes.push_back(result);
         prime_reported = 1'b1;
      end
      if (closes) begin
         if (!prime_reported) begin
            result.prime_value = '0;
            result.found = 1'b0;
            expected_primes.push_back(result);
         end
         prime_reported = 1'b0;
      end
   endtask

   task automatic add_request(input logic [VALUE_BITS-1:0] candidate, input logic closes,
                              input bit drain_first = 1'b0);
      sequence_request_type item;
      int unsigned d;
      item.candidate = candidate;
      item.closes = closes;
      item.drain_first = drain_first;
      pending_requests.push_back(item);
      cycle_budget += 3 + MAX_GAP + MAX_STALL_RUN;
      for (d = 2; d * d <= candidate; d++) cycle_budget += CYCLES_PER_DIVISOR;
   endtask

   task automatic report_mismatch(input string what);
      $display("MISMATCH at cycle %0d: %s", cycle_count, what);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         prime_reported = 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_first_prime(req_candidate, req_end_of_sequence);
         end
         if (req_valid && req_stall) begin
         end else if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_requests.size() != 0 &&
                      !(pending_requests[0].drain_first && expected_primes.size() != 0)) begin
            next_request = pending_requests.pop_front();
            req_valid <= 1'b1;
            req_candidate <= next_request.candidate;
            req_end_of_sequence <= next_request.closes;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                         : $urandom_range(1, 8);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, MAX_GAP);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (stall_phase_left == 0) begin
            stall_kind = stall_kind_type'($urandom_range(0, 2));
            stall_phase_left = $urandom_range(20, 300);
         end
         stall_phase_left--;
         case (stall_kind)
            STALL_NONE: begin
               rsp_stall <= 1'b0;
            end
            STALL_RANDOM: begin
               rsp_stall <= ($urandom_range(0, 1) == 1);
            end
            default: begin
               if (stall_run_left == 0) begin
                  stall_run_left = $urandom_range(1, MAX_STALL_RUN);
                  stall_level = ~stall_level;
               end
               stall_run_left--;
               rsp_stall <= stall_level;
            end
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_primes.size() == 0) begin
            report_mismatch($sformatf("unexpected response value %0d found %b",
                                      rsp_prime_value, rsp_found));
         end else begin
            seen_prime = expected_primes.pop_front();
            if (rsp_prime_value !== seen_prime.prime_value)
               report_mismatch($sformatf("prime_value %0d, expected %0d",
                                         rsp_prime_value, seen_prime.prime_value));
            if (rsp_found !== seen_prime.found)
               report_mismatch($sformatf("found %b, expected %b",
                                         rsp_found, seen_prime.found));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > cycle_limit) begin
         $display("Timeout after %0d cycles.", cycle_count);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin : stimulus
      int random_count;
      int seq_len;
      int flavor;
      int pick;
      int k;
      logic [VALUE_BITS-1:0] candidate;
      logic closes;

      // Zero and one never count as prime.
      add_request(16'd0, 1'b0);
      add_request(16'd1, 1'b1);
      add_request(16'd1, 1'b1);
      // Prime on the value that closes the sequence.
      add_request(16'd2, 1'b1);
      // Later values are skipped once a prime was reported.
      add_request(16'd4, 1'b0);
      add_request(16'd9, 1'b0);
      add_request(16'd3, 1'b0);
      add_request(16'd5, 1'b0);
      add_request(16'd7, 1'b1);
      add_request(16'hFFFF, 1'b0);
      add_request(16'd65521, 1'b1);
      add_request(16'hFFFF, 1'b1);
      add_request(16'd2, 1'b0);
      add_request(16'd65521, 1'b0);
      add_request(16'd0, 1'b1);
      // Squares of primes sit right on the divisor bound.
      add_request(16'd25, 1'b0);
      add_request(16'd49, 1'b0);
      add_request(16'd63001, 1'b0);
      add_request(16'd15, 1'b1);
      add_request(16'd3, 1'b1);
      add_request(16'd4, 1'b1);
      add_request(16'd32768, 1'b0);
      add_request(16'd65534, 1'b1);

      random_count = 0;
      while (random_count < RANDOM_REQUESTS) begin
         seq_len = $urandom_range(1, 6);
         flavor = $urandom_range(0, 9);
         for (k = 0; k < seq_len; k++) begin
            pick = $urandom_range(0, 9);
            if (flavor < 4) begin
               if (pick == 0) candidate = VALUE_BITS'($urandom_range(0, 1));
               else candidate = VALUE_BITS'($urandom_range(2, 255) * $urandom_range(2, 255));
               closes = (k == seq_len - 1);
            end else if (flavor < 9) begin
               if (pick < 5) candidate = VALUE_BITS'($urandom_range(0, 200));
               else if (pick < 8) candidate = VALUE_BITS'($urandom_range(0, 5000));
               else candidate = VALUE_BITS'($urandom_range(0, 65535));
               closes = (k == seq_len - 1);
            end else begin
               candidate = VALUE_BITS'($urandom_range(0, 65535));
               closes = ($urandom_range(0, 3) == 0);
            end
            add_request(candidate, closes, random_count == 0);
            random_count++;
         end
      end
      cycle_limit = int'(4 * cycle_budget) + 4 * TAIL_CYCLES + 50000;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (pending_requests.size() != 0 || req_valid) @(posedge clock);
      while (expected_primes.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
